[hdl/dqf_pkg.sv]
// Shared types and constants for the DNS query filter.
package dqf_pkg;

  localparam int MaxLabelsDefault = 127;
  localparam logic [15:0] MaxAdditionalReset = 16'd2;

  localparam logic [3:0] HdrLastIdx = 4'd11;
  localparam logic [5:0] MaxLabelLen = 6'd63;
  localparam logic [2:0] TailBytes = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_NAME_LEN = 3'd1,
    PH_LABEL    = 3'd2,
    PH_PTR2     = 3'd3,
    PH_TAIL     = 3'd4,
    PH_DONE     = 3'd5,
    PH_FAILED   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_SHORT_HDR = 3'd1,
    RSN_RESPONSE  = 3'd2,
    RSN_COUNTS    = 3'd3,
    RSN_LABEL     = 3'd4,
    RSN_TRUNC     = 3'd5
  } reason_t;

  typedef struct packed {
    reason_t    drop_reason;
    logic       verdict;
  } result_t;

endpackage

[hdl/dqf_parser.sv]
// Front end: walks header and question one byte per valid cycle, emits a verdict on the last byte.
module dqf_parser #(
  parameter int MAX_LABELS = dqf_pkg::MaxLabelsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [7:0]        payload_byte,
  input  logic              last_byte,
  input  logic [15:0]       max_additional,
  output logic              push,
  output dqf_pkg::result_t  result
);

  localparam logic [6:0] LabelLimit = 7'(MAX_LABELS);

  dqf_pkg::phase_t  parse_phase, parse_phase_next;
  logic [3:0]       header_index, header_index_next;
  logic [7:0]       additional_high_byte, additional_high_byte_next;
  logic [5:0]       label_bytes_left, label_bytes_left_next;
  logic [6:0]       labels_seen, labels_seen_next;
  logic [2:0]       tail_bytes_left, tail_bytes_left_next;
  dqf_pkg::reason_t latched_reason, latched_reason_next;
  logic             short_hdr;
  logic [15:0]      ar_count;
  logic [6:0]       labels_inc;

  assign ar_count   = {additional_high_byte, payload_byte};
  assign labels_inc = labels_seen + 7'd1;

  // next state
  always_comb begin
    parse_phase_next          = parse_phase;
    header_index_next         = header_index;
    additional_high_byte_next = additional_high_byte;
    label_bytes_left_next     = label_bytes_left;
    labels_seen_next          = labels_seen;
    tail_bytes_left_next      = tail_bytes_left;
    latched_reason_next       = latched_reason;
    short_hdr                 = 1'b0;
    case (parse_phase)
      dqf_pkg::PH_HEADER: begin
        if (header_index == 4'd2 && payload_byte[7]) begin
          if (latched_reason == dqf_pkg::RSN_NONE) latched_reason_next = dqf_pkg::RSN_RESPONSE;
        end else if (header_index == 4'd4 || (header_index >= 4'd6 && header_index <= 4'd9)) begin
          if (payload_byte != 8'd0 && latched_reason == dqf_pkg::RSN_NONE)
            latched_reason_next = dqf_pkg::RSN_COUNTS;
        end else if (header_index == 4'd5) begin
          if (payload_byte != 8'd1 && latched_reason == dqf_pkg::RSN_NONE)
            latched_reason_next = dqf_pkg::RSN_COUNTS;
        end else if (header_index == 4'd10) begin
          additional_high_byte_next = payload_byte;
        end else if (header_index == 4'd11) begin
          if (ar_count > max_additional && latched_reason == dqf_pkg::RSN_NONE)
            latched_reason_next = dqf_pkg::RSN_COUNTS;
        end
        if (header_index >= dqf_pkg::HdrLastIdx) begin
          parse_phase_next = (latched_reason_next != dqf_pkg::RSN_NONE) ?
                             dqf_pkg::PH_FAILED : dqf_pkg::PH_NAME_LEN;
        end else begin
          header_index_next = header_index + 4'd1;
          short_hdr         = 1'b1;
        end
      end
      dqf_pkg::PH_NAME_LEN: begin
        if (payload_byte[7:6] == 2'b11) begin
          parse_phase_next = dqf_pkg::PH_PTR2;
        end else if (payload_byte > {2'b00, dqf_pkg::MaxLabelLen}) begin
          if (latched_reason == dqf_pkg::RSN_NONE) latched_reason_next = dqf_pkg::RSN_LABEL;
          parse_phase_next = dqf_pkg::PH_FAILED;
        end else if (payload_byte == 8'd0) begin
          parse_phase_next     = dqf_pkg::PH_TAIL;
          tail_bytes_left_next = dqf_pkg::TailBytes;
        end else begin
          label_bytes_left_next = payload_byte[5:0];
          parse_phase_next      = dqf_pkg::PH_LABEL;
        end
      end
      dqf_pkg::PH_LABEL: begin
        label_bytes_left_next = label_bytes_left - 6'd1;
        if (label_bytes_left_next == 6'd0) begin
          labels_seen_next = labels_inc;
          if (labels_inc >= LabelLimit) begin
            parse_phase_next     = dqf_pkg::PH_TAIL;
            tail_bytes_left_next = dqf_pkg::TailBytes;
          end else begin
            parse_phase_next = dqf_pkg::PH_NAME_LEN;
          end
        end
      end
      dqf_pkg::PH_PTR2: begin
        parse_phase_next     = dqf_pkg::PH_TAIL;
        tail_bytes_left_next = dqf_pkg::TailBytes;
      end
      dqf_pkg::PH_TAIL: begin
        tail_bytes_left_next = tail_bytes_left - 3'd1;
        if (tail_bytes_left_next == 3'd0) parse_phase_next = dqf_pkg::PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    push = byte_valid && last_byte;
    if (short_hdr)
      result.drop_reason = dqf_pkg::RSN_SHORT_HDR;
    else if (latched_reason_next != dqf_pkg::RSN_NONE)
      result.drop_reason = latched_reason_next;
    else if (parse_phase_next == dqf_pkg::PH_DONE)
      result.drop_reason = dqf_pkg::RSN_NONE;
    else
      result.drop_reason = dqf_pkg::RSN_TRUNC;
    result.verdict = (result.drop_reason != dqf_pkg::RSN_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_valid && last_byte)) begin
      parse_phase          <= dqf_pkg::PH_HEADER;
      header_index         <= 4'd0;
      additional_high_byte <= 8'd0;
      label_bytes_left     <= 6'd0;
      labels_seen          <= 7'd0;
      tail_bytes_left      <= 3'd0;
      latched_reason       <= dqf_pkg::RSN_NONE;
    end else if (byte_valid) begin
      parse_phase          <= parse_phase_next;
      header_index         <= header_index_next;
      additional_high_byte <= additional_high_byte_next;
      label_bytes_left     <= label_bytes_left_next;
      labels_seen          <= labels_seen_next;
      tail_bytes_left      <= tail_bytes_left_next;
      latched_reason       <= latched_reason_next;
    end
  end

endmodule

[hdl/dqf_queue.sv]
// Back end: two-entry verdict queue that drives the result stream from registers.
module dqf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dqf_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output dqf_pkg::result_t  out_data
);

  dqf_pkg::result_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

[hdl/dns_query_filter_top.sv]
// Top level of the DNS query filter: byte stream in, one verdict item per packet out.
//
// Usage:
//   s_* carries the UDP payload of a DNS message, one byte per item, s_tlast on
//   the final byte. Header (12 bytes), question name and QTYPE/QCLASS are
//   checked as they pass. Each packet yields exactly one item on m_* when its
//   last byte is taken: verdict 0 accepts, 1 drops, with the drop reason.
//   cfg_* writes max_additional, the largest ARCOUNT still accepted; write it
//   only while no packet is in flight. cfg_ready is always high.
// Timing:
//   One byte per cycle while s_tready is high. The verdict is written into
//   a queue entry register as the last byte is accepted and is driven on m_* from it.
//   A two-entry verdict queue sits between parser and output; the parser
//   keeps taking bytes while the output is stalled and only stops (s_tready
//   low) once two verdicts are waiting.
// Reset:
//   rst clears the parser to the header phase, empties the queue and sets
//   max_additional to 2.
module dns_query_filter_top #(
  parameter int MAX_LABELS = dqf_pkg::MaxLabelsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] payload_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] verdict, [3:1] drop_reason, [7:4] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // max_additional
);

  logic [15:0]      max_additional;
  logic             q_full;
  logic             byte_take;
  logic             push;
  dqf_pkg::result_t result;
  dqf_pkg::result_t out_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign byte_take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_additional <= dqf_pkg::MaxAdditionalReset;
    end else if (cfg_valid) begin
      max_additional <= cfg_data;
    end
  end

  dqf_parser #(
    .MAX_LABELS(MAX_LABELS)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_take),
    .payload_byte   (s_tdata),
    .last_byte      (s_tlast),
    .max_additional (max_additional),
    .push           (push),
    .result         (result)
  );

  dqf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (q_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {4'b0000, out_data};

endmodule
